[rtl/annexb_pkg.sv]
// Package: beat types and constants of the Annex B NAL unit splitter.
package annexb_pkg;

  localparam int POSITION_BITS_DEF = 32;
  localparam int MAX_RESULTS       = 4;
  localparam int QUEUE_DEPTH       = MAX_RESULTS + 1;

  localparam logic [7:0] ZERO_BYTE     = 8'h00;
  localparam logic [7:0] START_BYTE    = 8'h01;
  localparam logic [7:0] NAL_TYPE_MASK = 8'h1F;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        unit_first;
    logic        unit_last;
    logic [4:0]  unit_type;
    logic [31:0] unit_offset;
    logic        run_end;
  } out_beat_t;

endpackage

[rtl/annexb_nal_unit_splitter.sv]
// Annex B start code parser: splits a byte stream into NAL unit payload beats.
// Each result beat is registered into the result queue when its input beat is taken.
// Input beats are taken one per cycle while each byte yields at most one beat
// and out_stall is low; a byte that yields n beats (up to four) enters the
// five-entry result queue and holds in_stall until the queue drains to one entry.
// Reset: synchronous, active low; clears parser state and empties the queue.
module annexb_nal_unit_splitter #(
  parameter int POSITION_BITS = annexb_pkg::POSITION_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  annexb_pkg::in_beat_t   in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output annexb_pkg::out_beat_t  out_data
);
  import annexb_pkg::*;

  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [POSITION_BITS-1:0] cur_off_r, cur_off_nxt;
  logic [1:0]  zrun_r, zrun_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        held_valid_r, held_valid_nxt;
  logic        inside_r, inside_nxt;
  logic        nfirst_r, nfirst_nxt;
  logic [4:0]  cur_type_r, cur_type_nxt;
  logic        spill_r, spill_nxt;
  logic [7:0]  spill_byte_r, spill_byte_nxt;

  out_beat_t   q_r [QUEUE_DEPTH];
  out_beat_t   q_nxt [QUEUE_DEPTH];
  logic [2:0]  cnt_r, cnt_nxt;

  out_beat_t   res [MAX_RESULTS];
  logic [2:0]  nout;
  logic [3:0]  total;

  logic [POSITION_BITS+31:0] off_ext;
  logic [31:0] off_sat;

  logic accept, pop;
  logic [7:0] b;
  logic       last_in;

  assign b       = in_data.data_byte;
  assign last_in = in_data.stream_end;
  assign in_stall  = (cnt_r > 3'(QUEUE_DEPTH - MAX_RESULTS));
  assign accept    = in_valid && !in_stall;
  assign out_valid = (cnt_r != 3'd0);
  assign pop       = out_valid && !out_stall;
  assign out_data  = q_r[0];

  assign off_ext = {32'd0, cur_off_r};
  assign off_sat = (|off_ext[POSITION_BITS+31:32]) ? 32'hFFFF_FFFF : off_ext[31:0];

  // parse one byte
  always_comb begin
    logic       is_start;
    logic       hm, mlast, he;
    logic [7:0] hb_m, hb_e;
    logic [1:0] zm, ze;
    logic [2:0] mlen, elen, j;
    logic [7:0] held_m;
    logic       held_valid_m, inside_m;
    logic [1:0] zrun_m;

    is_start     = (b == START_BYTE) && zrun_r[1];
    hm           = 1'b0;
    mlast        = 1'b0;
    hb_m         = held_r;
    zm           = 2'd0;
    held_m       = held_r;
    held_valid_m = held_valid_r;
    inside_m     = inside_r;
    zrun_m       = zrun_r;
    cur_off_nxt  = cur_off_r;

    if (b == ZERO_BYTE) begin
      if (zrun_r != 2'd3) begin
        zrun_m = zrun_r + 2'd1;
      end else if (inside_r) begin
        hm           = held_valid_r;
        held_m       = ZERO_BYTE;
        held_valid_m = 1'b1;
      end
    end else if (is_start) begin
      hm           = inside_r && held_valid_r;
      mlast        = 1'b1;
      held_m       = ZERO_BYTE;
      held_valid_m = 1'b0;
      zrun_m       = 2'd0;
      inside_m     = 1'b1;
      cur_off_nxt  = (&pos_r) ? pos_r : pos_r + 1'b1;
    end else begin
      if (inside_r) begin
        hm           = held_valid_r;
        zm           = zrun_r;
        held_m       = b;
        held_valid_m = 1'b1;
      end
      zrun_m = 2'd0;
    end

    he    = last_in && inside_m && held_valid_m;
    hb_e  = held_m;
    ze    = (last_in && inside_m) ? zrun_m : 2'd0;
    mlen  = {2'b00, hm} + {1'b0, zm};
    elen  = {2'b00, he} + {1'b0, ze};
    total = {1'b0, mlen} + {1'b0, elen};
    if (spill_r) begin
      nout = 3'd1;
    end else if (total > 4'(MAX_RESULTS)) begin
      nout = 3'(MAX_RESULTS);
    end else begin
      nout = total[2:0];
    end

    for (int k = 0; k < MAX_RESULTS; k++) begin
      j = 3'(k) - mlen;
      if (3'(k) < mlen) begin
        res[k].payload_byte = (hm && k == 0) ? hb_m : ZERO_BYTE;
        res[k].unit_last    = mlast && (3'(k) == mlen - 3'd1);
      end else begin
        res[k].payload_byte = (he && j == 3'd0) ? hb_e : ZERO_BYTE;
        res[k].unit_last    = (4'(k) == total - 4'd1);
      end
      res[k].unit_first  = nfirst_r && (k == 0);
      res[k].unit_offset = off_sat;
      res[k].run_end     = (3'(k) == nout - 3'd1);
    end
    for (int k = 0; k < MAX_RESULTS; k++) begin
      res[k].unit_type = nfirst_r ? 5'(res[0].payload_byte & NAL_TYPE_MASK) : cur_type_r;
    end

    if (spill_r) begin
      res[0].payload_byte = spill_byte_r;
      res[0].unit_first   = 1'b0;
      res[0].unit_last    = 1'b1;
      res[0].unit_type    = cur_type_r;
      res[0].run_end      = 1'b1;
    end

    spill_nxt      = !spill_r && (total == 4'(MAX_RESULTS + 1));
    spill_byte_nxt = (ze != 2'd0) ? ZERO_BYTE : hb_e;
    cur_type_nxt   = (res[0].unit_first && nout != 3'd0) ? res[0].unit_type : cur_type_r;

    if (last_in) begin
      pos_nxt        = '0;
      zrun_nxt       = 2'd0;
      held_nxt       = ZERO_BYTE;
      held_valid_nxt = 1'b0;
      inside_nxt     = 1'b0;
      nfirst_nxt     = 1'b0;
    end else begin
      pos_nxt        = (&pos_r) ? pos_r : pos_r + 1'b1;
      zrun_nxt       = zrun_m;
      held_nxt       = held_m;
      held_valid_nxt = held_valid_m;
      inside_nxt     = inside_m;
      if (is_start) begin
        nfirst_nxt = 1'b1;
      end else if (nout != 3'd0) begin
        nfirst_nxt = 1'b0;
      end else begin
        nfirst_nxt = nfirst_r;
      end
    end
  end

  // shift the result queue on pop, append the new beats behind it
  always_comb begin
    logic [2:0] base, slot;
    base = cnt_r - {2'b00, pop};
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      slot = 3'(i) - base;
      if (pop && i + 1 < QUEUE_DEPTH) begin
        q_nxt[i] = q_r[(i + 1 < QUEUE_DEPTH) ? i + 1 : i];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if (accept && 3'(i) >= base && 3'(i) < base + nout) begin
        q_nxt[i] = res[slot[1:0]];
      end
    end
    cnt_nxt = base + (accept ? nout : 3'd0);
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    if (!rst_n) begin
      cnt_r        <= 3'd0;
      pos_r        <= '0;
      cur_off_r    <= '0;
      zrun_r       <= 2'd0;
      held_r       <= ZERO_BYTE;
      held_valid_r <= 1'b0;
      inside_r     <= 1'b0;
      nfirst_r     <= 1'b0;
      cur_type_r   <= 5'd0;
      spill_r      <= 1'b0;
      spill_byte_r <= ZERO_BYTE;
    end else begin
      cnt_r <= cnt_nxt;
      if (accept) begin
        pos_r        <= pos_nxt;
        cur_off_r    <= cur_off_nxt;
        zrun_r       <= zrun_nxt;
        held_r       <= held_nxt;
        held_valid_r <= held_valid_nxt;
        inside_r     <= inside_nxt;
        nfirst_r     <= nfirst_nxt;
        cur_type_r   <= cur_type_nxt;
        spill_r      <= spill_nxt;
        spill_byte_r <= spill_byte_nxt;
      end
    end
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(QUEUE_DEPTH))
    else $error("result queue over capacity");

  a_burst_bound: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> total <= 4'(MAX_RESULTS + 1))
    else $error("byte yields more beats than queue plus spill");

  a_spill_clean: assert property (@(posedge clk) disable iff (!rst_n)
    spill_r |-> (!inside_r && !held_valid_r && zrun_r == 2'd0 && !nfirst_r))
    else $error("spill pending while parser not in reset state");

  a_stall_room: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> cnt_r <= 3'(QUEUE_DEPTH))
    else $error("accepted beat overran queue");

endmodule
